### hw/rtl/rsct_pkg.sv
package rsct_pkg;

  // field widths fixed by the item format
  localparam int unsigned IdW   = 24;
  localparam int unsigned MarkW = 8;
  localparam int unsigned ThrW  = 9;
  localparam int unsigned PosW  = 5;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_LISTED    = 3'd4,
    ST_NONE_ABV  = 3'd5
  } status_e;

  // one stored table entry
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [MarkW-1:0] mark;
  } entry_t;

  // one result transaction
  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   out_id;
    logic [MarkW-1:0] out_mark;
    logic [PosW-1:0]  position;
    logic             last;
  } res_t;

endpackage

### hw/rtl/rsct_if.sv
// request channel
interface rsct_in_if
  import rsct_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [IdW-1:0]         student_id;
  logic [MarkW-1:0]       student_mark;
  logic signed [ThrW-1:0] threshold;

  modport source (output valid, op, student_id, student_mark, threshold, input ready);
  modport sink   (input valid, op, student_id, student_mark, threshold, output ready);
endinterface

// result channel
interface rsct_out_if
  import rsct_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [IdW-1:0]   out_id;
  logic [MarkW-1:0] out_mark;
  logic [PosW-1:0]  position;
  logic             last;

  modport source (output valid, status, out_id, out_mark, position, last, input ready);
  modport sink   (input valid, status, out_id, out_mark, position, last, output ready);
endinterface

### hw/rtl/rsct_mem.sv
module rsct_mem
  import rsct_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/rsct_ctrl.sv
module rsct_ctrl
  import rsct_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsct_in_if.sink       in_i,
  rsct_out_if.source    out_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_FIN,
    S_LOOK,
    S_LIST,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          idx_q;
  logic [AW-1:0]          pos_q;
  logic [CW-1:0]          count_q;
  logic [IdW-1:0]         id_q;
  logic [MarkW-1:0]       mark_q;
  logic signed [ThrW-1:0] thr_q;
  res_t                   pend_q;
  logic                   pend_vld_q;
  logic                   out_vld_q;
  res_t                   out_q;

  logic can_emit, emit, hit, tail, qual, go;
  res_t res;

  assign can_emit = !out_vld_q || out_o.ready;
  assign hit      = (mem_rdata_i.id == id_q);
  assign tail     = ((CW'(idx_q) + CW'(1)) == count_q);
  assign qual     = ($signed({1'b0, mem_rdata_i.mark}) > thr_q);
  assign go       = !(pend_vld_q || !qual) || can_emit;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_q.status;
  assign out_o.out_id   = out_q.out_id;
  assign out_o.out_mark = out_q.out_mark;
  assign out_o.position = out_q.position;
  assign out_o.last     = out_q.last;

  // memory port control and result selection
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q + AW'(1);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q;
    emit        = 1'b0;
    res         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (op_e'(in_i.op) == OP_INSERT) begin
          mem_raddr_o = AW'(count_q - CW'(1));
        end else begin
          mem_raddr_o = '0;
        end
      end
      // walk upwards from the bottom, moving each smaller-or-equal entry down one
      S_INS_SCAN: begin
        if (mem_rdata_i.mark <= mark_q) begin
          mem_we_o = 1'b1;
          if (idx_q != '0) begin
            mem_raddr_o = idx_q - AW'(1);
          end
        end
      end
      S_INS_FIN: begin
        if (can_emit) begin
          mem_we_o       = 1'b1;
          mem_waddr_o    = pos_q;
          mem_wdata_o    = '{id: id_q, mark: mark_q};
          emit           = 1'b1;
          res.status     = ST_INSERTED;
          res.position   = PosW'(pos_q);
          res.last       = 1'b1;
        end
      end
      S_LOOK: begin
        if (hit) begin
          emit         = can_emit;
          res.status   = ST_FOUND;
          res.out_id   = mem_rdata_i.id;
          res.out_mark = mem_rdata_i.mark;
          res.position = PosW'(idx_q);
          res.last     = 1'b1;
        end else if (tail) begin
          emit       = can_emit;
          res.status = ST_NOT_FOUND;
          res.last   = 1'b1;
        end else begin
          mem_raddr_o = idx_q + AW'(1);
        end
      end
      // held entry goes out once the next one is known
      S_LIST: begin
        if ((pend_vld_q || !qual) && can_emit) begin
          emit = 1'b1;
          if (pend_vld_q) begin
            res      = pend_q;
            res.last = !qual;
          end else begin
            res.status = ST_NONE_ABV;
            res.last   = 1'b1;
          end
        end
        if (go && qual && !tail) begin
          mem_raddr_o = idx_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit = 1'b1;
          res  = pend_q;
        end
      end
      default: ;
    endcase
  end

  // sequencer, table fill and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      pos_q      <= '0;
      count_q    <= '0;
      id_q       <= '0;
      mark_q     <= '0;
      thr_q      <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
        out_q     <= res;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            id_q       <= in_i.student_id;
            mark_q     <= in_i.student_mark;
            thr_q      <= in_i.threshold;
            // first index matches the address read at acceptance
            idx_q      <= mem_raddr_o;
            pos_q      <= '0;
            pend_vld_q <= 1'b0;
            unique case (op_e'(in_i.op))
              OP_INSERT: begin
                if (count_q == CW'(DEPTH)) begin
                  pend_q  <= '{status: ST_FULL, out_id: '0, out_mark: '0,
                               position: '0, last: 1'b1};
                  state_q <= S_EMIT;
                end else if (count_q == '0) begin
                  state_q <= S_INS_FIN;
                end else begin
                  state_q <= S_INS_SCAN;
                end
              end
              OP_LOOKUP: begin
                if (count_q == '0) begin
                  pend_q  <= '{status: ST_NOT_FOUND, out_id: '0, out_mark: '0,
                               position: '0, last: 1'b1};
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_LOOK;
                end
              end
              OP_LIST: begin
                if (count_q == '0) begin
                  pend_q  <= '{status: ST_NONE_ABV, out_id: '0, out_mark: '0,
                               position: '0, last: 1'b1};
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_LIST;
                end
              end
              OP_NONE: ;
              default: ;
            endcase
          end
        end
        S_INS_SCAN: begin
          if (mem_rdata_i.mark > mark_q) begin
            pos_q   <= idx_q + AW'(1);
            state_q <= S_INS_FIN;
          end else if (idx_q == '0) begin
            pos_q   <= '0;
            state_q <= S_INS_FIN;
          end else begin
            idx_q <= idx_q - AW'(1);
          end
        end
        S_INS_FIN: begin
          if (can_emit) begin
            count_q <= count_q + CW'(1);
            state_q <= S_IDLE;
          end
        end
        S_LOOK: begin
          if (hit || tail) begin
            if (can_emit) begin
              state_q <= S_IDLE;
            end
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_LIST: begin
          if (go) begin
            if (!qual) begin
              state_q <= S_IDLE;
            end else begin
              pend_q     <= '{status: ST_LISTED, out_id: mem_rdata_i.id,
                              out_mark: mem_rdata_i.mark,
                              position: PosW'(idx_q), last: tail};
              pend_vld_q <= 1'b1;
              if (tail) begin
                state_q <= S_EMIT;
              end else begin
                idx_q <= idx_q + AW'(1);
              end
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above table size");

  // fill count only moves when an insert completes
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_INS_FIN) |=> $stable(count_q))
    else $error("fill count changed outside insert");

  // writes stay inside the occupied region plus one
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CW'(mem_waddr_o) <= count_q))
    else $error("write beyond fill count");

  // read-only operations never write the table
  a_ro_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK || state_q == S_LIST || state_q == S_EMIT) |-> !mem_we_o)
    else $error("table written during read-only operation");

endmodule

### hw/rtl/ranked_score_table.sv
// channel   dir  handshake     payload
// in_i      in   valid/ready   op, student_id, student_mark, threshold
// out_o     out  valid/ready   status, out_id, out_mark, position, last
//
// one request at a time; an insert gives its result once the one-entry-per-cycle
// shift through the table has made room; a lookup reads from the top to a hit or
// the last entry and a list to the first mark not above the threshold or the end,
// one table read per cycle unless a stalled result holds the list
// reset clears the fill count and sequencer; table contents are left as they are
// a stalled result holds the sequencer; the next request is taken once the last
// result is registered, even while it still waits in the output register
module ranked_score_table
  import rsct_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsct_in_if.sink     in_i,
  rsct_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // sequencer
  rsct_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry table
  rsct_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
